// ----- hw/rtl/skl_pkg.sv -----
`timescale 1ns / 1ps
package skl_pkg;

  // Field widths of one item and one result.
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 7;

  // Operation codes carried in func; the unused code is treated as a search.
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd2;

  // Status codes of a result.
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0]       func;
    logic signed [KEY_W-1:0] key;
  } skl_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  entry_count;
  } skl_out_t;

  // What one cell shows its neighbors.
  typedef struct packed {
    logic                    valid;
    logic signed [KEY_W-1:0] key;
    logic                    lt;
  } skl_link_t;

  // Broadcast control from the sequencer to every cell.
  typedef struct packed {
    logic                    cmp_en;
    logic signed [KEY_W-1:0] cmp_key;
    logic                    ins_en;
    logic                    del_en;
    logic signed [KEY_W-1:0] upd_key;
  } skl_ctrl_t;

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } skl_state_t;

endpackage

// ----- hw/rtl/skl_cell.sv -----
`timescale 1ns / 1ps
module skl_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  skl_pkg::skl_ctrl_t ctrl,
  input  skl_pkg::skl_link_t prev_link,
  input  skl_pkg::skl_link_t next_link,
  output skl_pkg::skl_link_t own_link,
  output logic               match
);
  import skl_pkg::*;

  logic                    valid_r;
  logic signed [KEY_W-1:0] key_r;
  logic                    lt_r;
  logic                    eq_r;

  // Compare flags are taken when an item is accepted; occupancy shifts with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      lt_r    <= 1'b0;
      eq_r    <= 1'b0;
    end else begin
      if (ctrl.cmp_en) begin
        lt_r <= valid_r && (key_r < ctrl.cmp_key);
        eq_r <= valid_r && (key_r == ctrl.cmp_key);
      end
      if (ctrl.ins_en) begin
        valid_r <= valid_r || prev_link.valid;
      end else if (ctrl.del_en && !lt_r) begin
        valid_r <= next_link.valid;
      end
    end
  end

  // Insert: the first cell not below the key takes it, cells after it take
  // their left neighbor. Delete: every cell from the match on takes its right neighbor.
  always_ff @(posedge clk) begin
    if (ctrl.ins_en && !lt_r) begin
      key_r <= prev_link.lt ? ctrl.upd_key : prev_link.key;
    end else if (ctrl.del_en && !lt_r) begin
      key_r <= next_link.key;
    end
  end

  // The first equal entry sits right after the last smaller one.
  assign match    = eq_r && prev_link.lt;
  assign own_link = '{valid: valid_r, key: key_r, lt: lt_r};

endmodule

// ----- hw/rtl/sorted_key_list.sv -----
`timescale 1ns / 1ps
// The block takes no new item until the last one has written its result; accepting an item
// registers the key compare in every cell of the chain, and the update state then shifts
// the chain and writes the result register.
// A result waiting in the output register stalls only the update cycle of the next item.
// Reset (synchronous, active low) empties the list at once; the count reads zero.
module sorted_key_list #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  skl_pkg::skl_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output skl_pkg::skl_out_t out_data
);
  import skl_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  skl_state_t              state_r;
  skl_state_t              state_nxt;
  logic [FUNC_W-1:0]       func_r;
  logic signed [KEY_W-1:0] key_r;
  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        count_nxt;
  logic                    out_valid_r;
  skl_out_t                out_data_r;
  logic                    in_fire;
  logic                    upd_fire;
  logic                    hit;
  logic                    full;
  logic [STATUS_W-1:0]     status_nxt;
  skl_ctrl_t               ctrl;
  skl_link_t               link_w [CAPACITY+2];
  logic [CAPACITY-1:0]     match_w;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_fire) state_nxt = ST_UPDATE;
      ST_UPDATE: if (upd_fire) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Handshake outputs of the sequencer.
  always_comb begin
    in_ready = 1'b0;
    upd_fire = 1'b0;
    unique case (state_r)
      ST_IDLE:   in_ready = 1'b1;
      ST_UPDATE: upd_fire = !out_valid_r || out_ready;
      default:   in_ready = 1'b0;
    endcase
  end

  assign in_fire = in_valid && in_ready;
  assign hit     = |match_w;
  assign full    = (count_r == CNT_W'(CAPACITY));

  // Status and count after the operation; search and the unused code keep the count.
  always_comb begin
    status_nxt = hit ? STATUS_OK : STATUS_NOT_FOUND;
    count_nxt  = count_r;
    unique case (func_r)
      FUNC_INSERT: begin
        status_nxt = full ? STATUS_FULL : STATUS_OK;
        if (!full) count_nxt = count_r + CNT_W'(1);
      end
      FUNC_DELETE: begin
        if (hit) count_nxt = count_r - CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  // Broadcast control to the chain.
  always_comb begin
    ctrl.cmp_en  = in_fire;
    ctrl.cmp_key = in_data.key;
    ctrl.ins_en  = upd_fire && (func_r == FUNC_INSERT) && !full;
    ctrl.del_en  = upd_fire && (func_r == FUNC_DELETE) && hit;
    ctrl.upd_key = key_r;
  end

  // Sequencer state, count and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (upd_fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item and result payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r <= in_data.func;
      key_r  <= in_data.key;
    end
    if (upd_fire) begin
      out_data_r.status      <= status_nxt;
      out_data_r.entry_count <= COUNT_W'(count_nxt);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Chain ends: the left end acts as an occupied entry below every key,
  // the right end as an empty entry.
  assign link_w[0]          = '{valid: 1'b1, key: '0, lt: 1'b1};
  assign link_w[CAPACITY+1] = '{valid: 1'b0, key: '0, lt: 1'b0};

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    skl_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .prev_link (link_w[i]),
      .next_link (link_w[i+2]),
      .own_link  (link_w[i+1]),
      .match     (match_w[i])
    );
  end

endmodule

// ----- hw/rtl/skl_chk.sv -----
`timescale 1ns / 1ps
module skl_chk #(
  parameter int unsigned CAPACITY = 64
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input skl_pkg::skl_in_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input skl_pkg::skl_out_t out_data
);
  import skl_pkg::*;

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // One item at a time: the port closes right after an item is taken.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is at work");

  // No result carries the unused status code.
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= STATUS_FULL)
    else $error("unused status code");

  // A refused insert is reported only with a full list.
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == STATUS_FULL |->
      out_data.entry_count == COUNT_W'(CAPACITY))
    else $error("full status with room left");

  // The count never exceeds the capacity; checked only while the capacity fits the count field.
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (CAPACITY > 127) || (out_data.entry_count <= COUNT_W'(CAPACITY)))
    else $error("count beyond capacity");

endmodule

bind sorted_key_list skl_chk #(.CAPACITY(CAPACITY)) u_skl_chk (.*);
